### rtl/core/fdde_pkg.sv
// Shared types and constants of the force-directed distance embedding engine.
package fdde_pkg;

    localparam int STRESS_BITS    = 48;
    localparam int FRAC_BITS      = 16;
    localparam int COORD_BITS     = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [STRESS_BITS-1:0] STRESS_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GEN_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_COUNT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIM_COUNT   = 2'd3;

    localparam logic [15:0] MOVE_FACTOR_RESET = 16'd328;
    localparam logic [15:0] GEN_COUNT_RESET   = 16'd500;
    localparam logic [6:0]  POINT_COUNT_RESET = 7'd2;
    localparam logic [2:0]  DIM_COUNT_RESET   = 3'd2;

    // Result kinds
    localparam logic KIND_COORD = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef enum logic [1:0] {
        MODE_WR_DIST,
        MODE_WR_COORD,
        MODE_RD_COORD,
        MODE_RUN
    } mode_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SQRT,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROW_RD,
        ST_ROW_CAP,
        ST_PAIR_RD,
        ST_PAIR_CAP,
        ST_SQ_WAIT,
        ST_ROOT_WAIT,
        ST_STRESS,
        ST_PROD_START,
        ST_PROD_WAIT,
        ST_DIV_WAIT,
        ST_FORCE_WR,
        ST_MOVE_RD,
        ST_MOVE_CAP,
        ST_MOVE_WAIT
    } state_t;

endpackage

### rtl/core/force_directed_distance_embedding_top.sv
// Top level of the force-directed distance embedding engine.
//
// Input items (valid/ready): mode selects write target distance, write
// coordinate, read coordinate or run. Writes give no result. A coordinate
// read gives one result item, registered after the RAM read and the read
// state, or straight from the accept when its index is out of range.
// A run gives one result item with the total stress of the last generation.
// Run length: every pair step goes through one shared bit-serial unit: a
// square per dimension and a square root for each pair, plus a multiply and
// a division per dimension when its distance misses the target (the unit
// works on RB = VALUE_BITS + 1 bits for four dimensions). Each generation
// also loads rows, writes forces and moves; a run is generation_count of them.
// Configuration is a plain write port, taken in any cycle.
// After reset the block sweeps the coordinate memory to zero, one entry a
// cycle, and takes no item until done.
// The result sits in an output register: while the receiver stalls, writes
// are not taken either; the block takes the next item in the cycle the
// result leaves.
module force_directed_distance_embedding_top
    import fdde_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [5:0]                 row_point,
    input  logic [5:0]                 column_select,
    input  logic signed [31:0]         data_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_kind,
    output logic signed [31:0]         coordinate_out,
    output logic [STRESS_BITS-1:0]     total_stress
);

    localparam int VB     = VALUE_BITS;
    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int DM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW     = PT_W + 1;
    localparam int KW     = DM_W + 1;
    localparam int CLOG_D = $clog2(MAX_DIMS);
    localparam int RB     = VB + (CLOG_D + 1) / 2;
    localparam int WIDE   = 2 * RB;
    localparam int BW     = 2 * RB + 4;
    localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
    localparam int PA_W   = $clog2(PDEPTH);
    localparam int TDEPTH = MAX_POINTS * MAX_POINTS;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int STS_W  = ((RB > STRESS_BITS) ? RB : STRESS_BITS) + 1;

    localparam logic signed [BW-1:0] VMAX_W = $signed({{(BW-VB+1){1'b0}}, {(VB-1){1'b1}}});
    localparam logic signed [BW-1:0] VMIN_W = $signed({{(BW-VB+1){1'b1}}, {(VB-1){1'b0}}});
    localparam logic signed [BW-1:0] CMAX_W = $signed({{(BW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [BW-1:0] CMIN_W = $signed({{(BW-31){1'b1}}, {31{1'b0}}});

    // Clamp a wide value to the coordinate range
    function automatic logic signed [VB-1:0] sat_vb(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] c;
        c = v;
        if (v > VMAX_W)
        begin
            c = VMAX_W;
        end
        else if (v < VMIN_W)
        begin
            c = VMIN_W;
        end
        return VB'(c);
    endfunction

    function automatic logic [PA_W-1:0] pos_addr(input logic [PT_W-1:0] p,
                                                 input logic [DM_W-1:0] d);
        return PA_W'(32'(p) * MAX_DIMS + 32'(d));
    endfunction

    function automatic logic [TA_W-1:0] tgt_addr(input logic [PT_W-1:0] r,
                                                 input logic [PT_W-1:0] c);
        return TA_W'(32'(r) * MAX_POINTS + 32'(c));
    endfunction

    // Registers
    state_t                      state_reg, state_next;
    logic [15:0]                 mf_reg, mf_next;
    logic [15:0]                 gc_reg, gc_next;
    logic [6:0]                  pc_reg, pc_next;
    logic [2:0]                  dc_reg, dc_next;
    logic [PA_W-1:0]             clr_reg, clr_next;
    logic [PT_W-1:0]             i_reg, i_next;
    logic [PT_W-1:0]             j_reg, j_next;
    logic [DM_W-1:0]             k_reg, k_next;
    logic [15:0]                 g_reg, g_next;
    logic [NW-1:0]               n_reg, n_next;
    logic [KW-1:0]               nd_reg, nd_next;
    logic signed [VB-1:0]        pos_i_reg [MAX_DIMS];
    logic signed [VB-1:0]        pos_i_next [MAX_DIMS];
    logic signed [VB:0]          diff_reg [MAX_DIMS];
    logic signed [VB:0]          diff_next [MAX_DIMS];
    logic signed [VB-1:0]        force_reg [MAX_DIMS];
    logic signed [VB-1:0]        force_next [MAX_DIMS];
    logic [WIDE-1:0]             sum_reg, sum_next;
    logic [RB-1:0]               dist_reg, dist_next;
    logic [RB-1:0]               dmag_reg, dmag_next;
    logic                        dneg_reg, dneg_next;
    logic signed [VB-1:0]        pos_m_reg, pos_m_next;
    logic                        fneg_reg, fneg_next;
    logic [STRESS_BITS-1:0]      row_stress_reg, row_stress_next;
    logic [STRESS_BITS-1:0]      total_reg, total_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        kind_reg, kind_next;
    logic signed [31:0]          coord_reg, coord_next;
    logic [STRESS_BITS-1:0]      stress_out_reg, stress_out_next;

    // Memory ports
    logic                        pos_we, pos_re;
    logic [PA_W-1:0]             pos_a;
    logic [VB-1:0]               pos_wd, pos_rd;
    logic                        frc_we, frc_re;
    logic [PA_W-1:0]             frc_a;
    logic [VB-1:0]               frc_wd, frc_rd;
    logic                        tgt_we, tgt_re;
    logic [TA_W-1:0]             tgt_a;
    logic [VB-1:0]               tgt_wd, tgt_rd;

    // Shared unit
    alu_ctl_t                    alu_ctl;
    logic [WIDE-1:0]             alu_a;
    logic [RB-1:0]               alu_b;
    logic [WIDE-1:0]             alu_res;
    logic                        alu_done;

    // Decode and loop helpers
    logic                        accept;
    mode_t                       in_mode;
    logic                        row_ok, dim_ok, colp_ok;
    logic signed [VB-1:0]        in_val;
    logic                        last_k, last_i, last_gen, end_row;
    logic [NW-1:0]               j_adv;
    logic                        run_go;
    logic [NW-1:0]               n_eff;
    logic [KW-1:0]               nd_eff;
    logic signed [VB:0]          diff_w;
    logic signed [RB:0]          delta_w;
    logic [RB-1:0]               delta_mag;
    logic [STS_W-1:0]            stress_sum;
    logic [STS_W-1:0]            total_sum;

    assign in_mode  = mode_t'(mode);
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign row_ok   = 32'(row_point) < MAX_POINTS;
    assign dim_ok   = 32'(column_select) < MAX_DIMS;
    assign colp_ok  = 32'(column_select) < MAX_POINTS;
    assign in_val   = sat_vb(BW'(data_value));

    assign n_eff  = (32'(pc_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pc_reg);
    assign nd_eff = (dc_reg == 3'd0) ? KW'(1) :
                    ((32'(dc_reg) > MAX_DIMS) ? KW'(MAX_DIMS) : KW'(dc_reg));
    assign run_go = (gc_reg != 16'd0) && (n_eff >= NW'(2));

    assign last_k   = (KW'(k_reg) + KW'(1)) == nd_reg;
    assign last_i   = (NW'(i_reg) + NW'(1)) == n_reg;
    assign last_gen = (17'(g_reg) + 17'd1) == 17'(gc_reg);

    // Next pair column, skipping the diagonal
    always_comb
    begin
        j_adv = NW'(j_reg) + NW'(1);
        if (j_adv == NW'(i_reg))
        begin
            j_adv = j_adv + NW'(1);
        end
    end
    assign end_row = j_adv >= n_reg;

    assign diff_w    = (VB+1)'($signed(pos_rd)) - (VB+1)'(pos_i_reg[k_reg]);
    assign delta_w   = $signed({1'b0, dist_reg}) - (RB+1)'($signed(tgt_rd));
    assign delta_mag = delta_w[RB] ? RB'(-delta_w) : RB'(delta_w);
    assign stress_sum = STS_W'(row_stress_reg) + STS_W'(delta_mag);
    assign total_sum  = STS_W'(total_reg) + STS_W'(row_stress_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PA_W'(PDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && in_mode == MODE_RD_COORD && row_ok && dim_ok)
                begin
                    state_next = ST_READ;
                end
                else if (accept && in_mode == MODE_RUN && run_go)
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_READ:       state_next = ST_IDLE;
            ST_ROW_RD:     state_next = ST_ROW_CAP;
            ST_ROW_CAP:    state_next = last_k ? ST_PAIR_RD : ST_ROW_RD;
            ST_PAIR_RD:    state_next = ST_PAIR_CAP;
            ST_PAIR_CAP:   state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = last_k ? ST_ROOT_WAIT : ST_PAIR_RD;
                end
            end
            ST_ROOT_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_STRESS;
                end
            end
            ST_STRESS:
            begin
                if (delta_w != '0)
                begin
                    state_next = ST_PROD_START;
                end
                else
                begin
                    state_next = end_row ? ST_FORCE_WR : ST_PAIR_RD;
                end
            end
            ST_PROD_START: state_next = ST_PROD_WAIT;
            ST_PROD_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (alu_done)
                begin
                    if (!last_k)
                    begin
                        state_next = ST_PROD_START;
                    end
                    else
                    begin
                        state_next = end_row ? ST_FORCE_WR : ST_PAIR_RD;
                    end
                end
            end
            ST_FORCE_WR:
            begin
                if (last_k)
                begin
                    state_next = last_i ? ST_MOVE_RD : ST_ROW_RD;
                end
            end
            ST_MOVE_RD:    state_next = ST_MOVE_CAP;
            ST_MOVE_CAP:   state_next = ST_MOVE_WAIT;
            ST_MOVE_WAIT:
            begin
                if (alu_done)
                begin
                    if (last_k && last_i)
                    begin
                        state_next = last_gen ? ST_IDLE : ST_ROW_RD;
                    end
                    else
                    begin
                        state_next = ST_MOVE_RD;
                    end
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory and unit controls
    always_comb
    begin
        mf_next         = mf_reg;
        gc_next         = gc_reg;
        pc_next         = pc_reg;
        dc_next         = dc_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        g_next          = g_reg;
        n_next          = n_reg;
        nd_next         = nd_reg;
        pos_i_next      = pos_i_reg;
        diff_next       = diff_reg;
        force_next      = force_reg;
        sum_next        = sum_reg;
        dist_next       = dist_reg;
        dmag_next       = dmag_reg;
        dneg_next       = dneg_reg;
        pos_m_next      = pos_m_reg;
        fneg_next       = fneg_reg;
        row_stress_next = row_stress_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        coord_next      = coord_reg;
        stress_out_next = stress_out_reg;
        pos_we          = 1'b0;
        pos_re          = 1'b0;
        pos_a           = pos_addr(i_reg, k_reg);
        pos_wd          = '0;
        frc_we          = 1'b0;
        frc_re          = 1'b0;
        frc_a           = pos_addr(i_reg, k_reg);
        frc_wd          = force_reg[k_reg];
        tgt_we          = 1'b0;
        tgt_re          = 1'b0;
        tgt_a           = tgt_addr(i_reg, j_reg);
        tgt_wd          = '0;
        alu_ctl.start   = 1'b0;
        alu_ctl.op      = ALU_MUL;
        alu_a           = '0;
        alu_b           = '0;

        // Take configuration writes at any time
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOVE_FACTOR: mf_next = cfg_data;
                CFG_GEN_COUNT:   gc_next = cfg_data;
                CFG_POINT_COUNT: pc_next = cfg_data[6:0];
                CFG_DIM_COUNT:   dc_next = cfg_data[2:0];
                default:         mf_next = mf_reg;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                pos_we   = 1'b1;
                pos_a    = clr_reg;
                clr_next = clr_reg + PA_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode)
                        MODE_WR_DIST:
                        begin
                            tgt_we = row_ok && colp_ok;
                            tgt_a  = tgt_addr(PT_W'(row_point), PT_W'(column_select));
                            tgt_wd = in_val[VB-1] ? '0 : in_val;
                        end
                        MODE_WR_COORD:
                        begin
                            pos_we = row_ok && dim_ok;
                            pos_a  = pos_addr(PT_W'(row_point), DM_W'(column_select));
                            pos_wd = in_val;
                        end
                        MODE_RD_COORD:
                        begin
                            pos_re    = row_ok && dim_ok;
                            pos_a     = pos_addr(PT_W'(row_point), DM_W'(column_select));
                            kind_next = KIND_COORD;
                            stress_out_next = '0;
                            if (!(row_ok && dim_ok))
                            begin
                                out_valid_next = 1'b1;
                                coord_next     = '0;
                            end
                        end
                        MODE_RUN:
                        begin
                            n_next     = n_eff;
                            nd_next    = nd_eff;
                            g_next     = '0;
                            i_next     = '0;
                            k_next     = '0;
                            total_next = '0;
                            if (!run_go)
                            begin
                                out_valid_next  = 1'b1;
                                kind_next       = KIND_RUN;
                                coord_next      = '0;
                                stress_out_next = '0;
                            end
                        end
                        default:
                        begin
                            pos_re = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Saturate the stored coordinate to the readback width
                if (BW'($signed(pos_rd)) > CMAX_W)
                begin
                    coord_next = 32'(CMAX_W);
                end
                else if (BW'($signed(pos_rd)) < CMIN_W)
                begin
                    coord_next = 32'(CMIN_W);
                end
                else
                begin
                    coord_next = 32'(BW'($signed(pos_rd)));
                end
                out_valid_next = 1'b1;
            end
            ST_ROW_RD:
            begin
                pos_re = 1'b1;
            end
            ST_ROW_CAP:
            begin
                pos_i_next[k_reg] = $signed(pos_rd);
                force_next[k_reg] = '0;
                if (last_k)
                begin
                    k_next          = '0;
                    row_stress_next = '0;
                    j_next          = (i_reg == '0) ? PT_W'(1) : '0;
                end
                else
                begin
                    k_next = k_reg + DM_W'(1);
                end
            end
            ST_PAIR_RD:
            begin
                pos_re = 1'b1;
                pos_a  = pos_addr(j_reg, k_reg);
                if (k_reg == '0)
                begin
                    tgt_re   = 1'b1;
                    sum_next = '0;
                end
            end
            ST_PAIR_CAP:
            begin
                // Replace a zero difference by one LSB and square it
                diff_next[k_reg] = (diff_w == '0) ? (VB+1)'(1) : diff_w;
                alu_ctl.start    = 1'b1;
                alu_ctl.op       = ALU_MUL;
                if (diff_w == '0)
                begin
                    alu_a = WIDE'(1);
                    alu_b = RB'(1);
                end
                else
                begin
                    alu_a = diff_w[VB] ? WIDE'(-diff_w) : WIDE'(diff_w);
                    alu_b = diff_w[VB] ? RB'(-diff_w) : RB'(diff_w);
                end
            end
            ST_SQ_WAIT:
            begin
                if (alu_done)
                begin
                    sum_next = sum_reg + alu_res;
                    if (last_k)
                    begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.op    = ALU_SQRT;
                        alu_a         = sum_reg + alu_res;
                        k_next        = '0;
                    end
                    else
                    begin
                        k_next = k_reg + DM_W'(1);
                    end
                end
            end
            ST_ROOT_WAIT:
            begin
                if (alu_done)
                begin
                    dist_next = alu_res[RB-1:0];
                end
            end
            ST_STRESS:
            begin
                row_stress_next = (stress_sum > STS_W'(STRESS_MAX)) ? STRESS_MAX :
                                  STRESS_BITS'(stress_sum);
                dmag_next = delta_mag;
                dneg_next = delta_w[RB];
                k_next    = '0;
                if (delta_w == '0 && !end_row)
                begin
                    j_next = PT_W'(j_adv);
                end
            end
            ST_PROD_START:
            begin
                alu_ctl.start = 1'b1;
                alu_ctl.op    = ALU_MUL;
                alu_a         = WIDE'(dmag_reg);
                alu_b         = diff_reg[k_reg][VB] ? RB'(-diff_reg[k_reg]) :
                                                      RB'(diff_reg[k_reg]);
            end
            ST_PROD_WAIT:
            begin
                if (alu_done)
                begin
                    alu_ctl.start = 1'b1;
                    alu_ctl.op    = ALU_DIV;
                    alu_a         = alu_res;
                    alu_b         = dist_reg;
                end
            end
            ST_DIV_WAIT:
            begin
                if (alu_done)
                begin
                    // Accumulate the force with the combined sign
                    if (dneg_reg != diff_reg[k_reg][VB])
                    begin
                        force_next[k_reg] = sat_vb(BW'(force_reg[k_reg]) -
                                                   $signed(BW'(alu_res[RB-1:0])));
                    end
                    else
                    begin
                        force_next[k_reg] = sat_vb(BW'(force_reg[k_reg]) +
                                                   $signed(BW'(alu_res[RB-1:0])));
                    end
                    if (last_k)
                    begin
                        k_next = '0;
                        if (!end_row)
                        begin
                            j_next = PT_W'(j_adv);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + DM_W'(1);
                    end
                end
            end
            ST_FORCE_WR:
            begin
                frc_we = 1'b1;
                if (last_k)
                begin
                    k_next     = '0;
                    total_next = (total_sum > STS_W'(STRESS_MAX)) ? STRESS_MAX :
                                 STRESS_BITS'(total_sum);
                    i_next     = last_i ? '0 : i_reg + PT_W'(1);
                end
                else
                begin
                    k_next = k_reg + DM_W'(1);
                end
            end
            ST_MOVE_RD:
            begin
                pos_re = 1'b1;
                frc_re = 1'b1;
            end
            ST_MOVE_CAP:
            begin
                pos_m_next    = $signed(pos_rd);
                fneg_next     = frc_rd[VB-1];
                alu_ctl.start = 1'b1;
                alu_ctl.op    = ALU_MUL;
                alu_a         = frc_rd[VB-1] ? WIDE'(-$signed(frc_rd)) : WIDE'(frc_rd);
                alu_b         = RB'(mf_reg);
            end
            ST_MOVE_WAIT:
            begin
                if (alu_done)
                begin
                    // Move the point by the scaled force
                    pos_we = 1'b1;
                    if (fneg_reg)
                    begin
                        pos_wd = sat_vb(BW'(pos_m_reg) -
                                        $signed(BW'(alu_res[FRAC_BITS +: VB])));
                    end
                    else
                    begin
                        pos_wd = sat_vb(BW'(pos_m_reg) +
                                        $signed(BW'(alu_res[FRAC_BITS +: VB])));
                    end
                    if (last_k)
                    begin
                        k_next = '0;
                        if (last_i)
                        begin
                            i_next = '0;
                            g_next = g_reg + 16'd1;
                            if (last_gen)
                            begin
                                out_valid_next  = 1'b1;
                                kind_next       = KIND_RUN;
                                coord_next      = '0;
                                stress_out_next = total_reg;
                            end
                            else
                            begin
                                total_next = '0;
                            end
                        end
                        else
                        begin
                            i_next = i_reg + PT_W'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + DM_W'(1);
                    end
                end
            end
            default:
            begin
                pos_re = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mf_reg        <= MOVE_FACTOR_RESET;
            gc_reg        <= GEN_COUNT_RESET;
            pc_reg        <= POINT_COUNT_RESET;
            dc_reg        <= DIM_COUNT_RESET;
            clr_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            g_reg         <= '0;
            n_reg         <= '0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mf_reg        <= mf_next;
            gc_reg        <= gc_next;
            pc_reg        <= pc_next;
            dc_reg        <= dc_next;
            clr_reg       <= clr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            g_reg         <= g_next;
            n_reg         <= n_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pos_i_reg      <= pos_i_next;
        diff_reg       <= diff_next;
        force_reg      <= force_next;
        sum_reg        <= sum_next;
        dist_reg       <= dist_next;
        dmag_reg       <= dmag_next;
        dneg_reg       <= dneg_next;
        pos_m_reg      <= pos_m_next;
        fneg_reg       <= fneg_next;
        row_stress_reg <= row_stress_next;
        total_reg      <= total_next;
        kind_reg       <= kind_next;
        coord_reg      <= coord_next;
        stress_out_reg <= stress_out_next;
    end

    fdde_ram #(
        .WIDTH (VB),
        .DEPTH (PDEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .re    (pos_re),
        .addr  (pos_a),
        .wdata (pos_wd),
        .rdata (pos_rd)
    );

    fdde_ram #(
        .WIDTH (VB),
        .DEPTH (PDEPTH)
    ) u_force_ram (
        .clk   (clk),
        .we    (frc_we),
        .re    (frc_re),
        .addr  (frc_a),
        .wdata (frc_wd),
        .rdata (frc_rd)
    );

    fdde_ram #(
        .WIDTH (VB),
        .DEPTH (TDEPTH)
    ) u_target_ram (
        .clk   (clk),
        .we    (tgt_we),
        .re    (tgt_re),
        .addr  (tgt_a),
        .wdata (tgt_wd),
        .rdata (tgt_rd)
    );

    fdde_iter_unit #(
        .ROOT_BITS (RB)
    ) u_iter_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_res),
        .done   (alu_done)
    );

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign coordinate_out = coord_reg;
    assign total_stress   = stress_out_reg;

endmodule

### rtl/core/fdde_ram.sv
// Generic single-port RAM with registered read data.
module fdde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/core/fdde_iter_unit.sv
// Shared bit-serial unit: shift-add multiply, integer square root, long division.
module fdde_iter_unit
    import fdde_pkg::*;
#(
    parameter int ROOT_BITS = 33
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  alu_ctl_t                 ctl,
    input  logic [2*ROOT_BITS-1:0]   opa,
    input  logic [ROOT_BITS-1:0]     opb,
    output logic [2*ROOT_BITS-1:0]   result,
    output logic                     done
);

    localparam int RB   = ROOT_BITS;
    localparam int WIDE = 2 * ROOT_BITS;
    localparam int CW   = $clog2(WIDE + 1);

    logic [WIDE-1:0] x_reg, x_next;
    logic [RB-1:0]   y_reg, y_next;
    logic [WIDE-1:0] acc_reg, acc_next;
    logic [RB+1:0]   rem_reg, rem_next;
    logic [CW-1:0]   count_reg, count_next;
    alu_op_t         op_reg, op_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [RB+1:0]   rem_sh;
    logic [RB+1:0]   trial;
    logic [CW-1:0]   last_count;

    // Step the selected operation by one bit
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        op_next    = op_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_sh     = '0;
        trial      = '0;
        last_count = CW'(RB - 1);
        if (ctl.start)
        begin
            op_next    = ctl.op;
            busy_next  = 1'b1;
            count_next = '0;
            x_next     = opa;
            y_next     = (ctl.op == ALU_SQRT) ? '0 : opb;
            acc_next   = '0;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[WIDE-2:0], 1'b0};
                    y_next = {1'b0, y_reg[RB-1:1]};
                end
                ALU_SQRT:
                begin
                    rem_sh = {rem_reg[RB-1:0], x_reg[WIDE-1 -: 2]};
                    trial  = {y_reg, 2'b01};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        y_next   = {y_reg[RB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        y_next   = {y_reg[RB-2:0], 1'b0};
                    end
                    x_next = {x_reg[WIDE-3:0], 2'b00};
                end
                ALU_DIV:
                begin
                    last_count = CW'(WIDE - 1);
                    rem_sh     = {rem_reg[RB:0], x_reg[WIDE-1]};
                    if (rem_sh >= {2'b00, y_reg})
                    begin
                        rem_next = rem_sh - {2'b00, y_reg};
                        x_next   = {x_reg[WIDE-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        x_next   = {x_reg[WIDE-2:0], 1'b0};
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            count_next = count_reg + CW'(1);
            if (count_reg == last_count)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= ALU_MUL;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    // Select the finished value
    always_comb
    begin
        unique case (op_reg)
            ALU_MUL:  result = acc_reg;
            ALU_SQRT: result = WIDE'(y_reg);
            ALU_DIV:  result = x_reg;
            default:  result = acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

### dv/tb.sv
// Testbench for the force-directed distance embedding engine: random and directed items, scoreboard.
module tb;
    import fdde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int NDIM = 4;
    localparam longint SMAX = (64'd1 << 48) - 1;

    typedef struct {
        mode_t       op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] data;
    } load_item_t;

    typedef struct {
        logic                kind;
        logic signed [31:0]  coord;
        logic [47:0]         stress;
    } embed_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic [5:0] row_point = '0;
    logic [5:0] column_select = '0;
    logic signed [31:0] data_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic result_kind;
    logic signed [31:0] coordinate_out;
    logic [STRESS_BITS-1:0] total_stress;

    force_directed_distance_embedding_top dut (.*);

    // Mirror of block state
    longint coord_mem[NPTS*NDIM];
    longint target_mem[NPTS*NPTS];
    bit     target_set[NPTS*NPTS];
    int unsigned step_gain = MOVE_FACTOR_RESET;
    int unsigned gen_total = GEN_COUNT_RESET;
    int unsigned pts_used = POINT_COUNT_RESET;
    int unsigned dims_used = DIM_COUNT_RESET;

    load_item_t    pending_items[$];
    embed_result_t expected_results[$];
    int  errors = 0;
    int  n_runs = 0;
    int  n_reads = 0;
    int  n_writes = 0;
    int  cycle_cnt = 0;
    bit  calm;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Run all generations on the mirrored state and return the final total stress
    function automatic logic [47:0] embed_generations();
        int n, nd, g, i, j, k, b;
        longint frc[NPTS*NDIM];
        longint diff[NDIM];
        longint pstress[NPTS];
        longint d, span, delta, dmag, q, f, stp, tot;
        logic [127:0] sq_sum, prod, t;
        logic [63:0] r;
        bit neg;
        n = pts_used > NPTS ? NPTS : pts_used;
        nd = dims_used > NDIM ? NDIM : dims_used;
        if (nd == 0)
            nd = 1;
        tot = 0;
        for (g = 0; g < gen_total; g++)
        begin
            for (i = 0; i < n; i++)
            begin
                pstress[i] = 0;
                for (k = 0; k < nd; k++)
                    frc[i*NDIM+k] = 0;
            end
            for (i = 0; i < n; i++)
            begin
                for (j = 0; j < n; j++)
                begin
                    if (i == j)
                        continue;
                    sq_sum = '0;
                    for (k = 0; k < nd; k++)
                    begin
                        d = coord_mem[j*NDIM+k] - coord_mem[i*NDIM+k];
                        if (d == 0)
                            d = 1;
                        diff[k] = d;
                        t = {64'd0, mag(d)};
                        sq_sum = sq_sum + t * t;
                    end
                    r = '0;
                    for (b = 63; b >= 0; b--)
                    begin
                        t = {64'd0, r | (64'd1 << b)};
                        if (t * t <= sq_sum)
                            r = t[63:0];
                    end
                    span = longint'(r);
                    delta = span - target_mem[i*NPTS+j];
                    dmag = mag(delta);
                    pstress[i] = pstress[i] + dmag;
                    if (pstress[i] > SMAX)
                        pstress[i] = SMAX;
                    if (delta == 0)
                        continue;
                    for (k = 0; k < nd; k++)
                    begin
                        prod = {64'd0, dmag} * {64'd0, mag(diff[k])};
                        prod = prod / {64'd0, span};
                        q = prod[63:0];
                        neg = (delta < 0) != (diff[k] < 0);
                        f = frc[i*NDIM+k];
                        frc[i*NDIM+k] = sat32(neg ? f - q : f + q);
                    end
                end
            end
            tot = 0;
            for (i = 0; i < n; i++)
            begin
                tot = tot + pstress[i];
                if (tot > SMAX)
                    tot = SMAX;
            end
            for (i = 0; i < n; i++)
            begin
                for (k = 0; k < nd; k++)
                begin
                    f = frc[i*NDIM+k];
                    stp = (mag(f) * longint'(step_gain)) >>> 16;
                    coord_mem[i*NDIM+k] = sat32(f < 0 ? coord_mem[i*NDIM+k] - stp
                                                      : coord_mem[i*NDIM+k] + stp);
                end
            end
        end
        return tot[47:0];
    endfunction

    // Update the mirror for one accepted item and queue its result, if it has one
    function automatic void predict_item(mode_t op, logic [5:0] row, logic [5:0] col,
                                         logic signed [31:0] data);
        embed_result_t res;
        longint v;
        v = longint'(data);
        res.kind = KIND_COORD;
        res.coord = '0;
        res.stress = '0;
        case (op)
            MODE_WR_DIST:
            begin
                target_mem[row*NPTS+col] = v < 0 ? 0 : v;
                n_writes++;
            end
            MODE_WR_COORD:
            begin
                if (col < NDIM)
                    coord_mem[row*NDIM+col] = v;
                n_writes++;
            end
            MODE_RD_COORD:
            begin
                if (col < NDIM)
                    res.coord = 32'(coord_mem[row*NDIM+col]);
                expected_results = {expected_results, res};
                n_reads++;
            end
            default:
            begin
                res.kind = KIND_RUN;
                res.stress = embed_generations();
                expected_results = {expected_results, res};
                n_runs++;
            end
        endcase
    endfunction

    // Calm stretch: no idling on either side
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end
    assign calm = (cycle_cnt % 60000) >= 30000 && (cycle_cnt % 60000) < 38000;

    // Drive input items from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        load_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_item(mode_t'(mode), row_point, column_select, data_value);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 27))
                begin
                    it = pending_items.pop_front();
                    mode <= it.op;
                    row_point <= it.row;
                    column_select <= it.col;
                    data_value <= it.data;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || $urandom_range(99) >= 27;
    end

    // Check each result item against the oldest expectation
    always @(posedge clk)
    begin
        embed_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d coord=%0d stress=%0d", $time,
                         result_kind, coordinate_out, total_stress);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result_kind !== exp_r.kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             exp_r.kind, result_kind);
                    errors++;
                end
                if (coordinate_out !== exp_r.coord)
                begin
                    $display("%0t: coordinate_out expected %0d actual %0d", $time,
                             exp_r.coord, coordinate_out);
                    errors++;
                end
                if (total_stress !== exp_r.stress)
                begin
                    $display("%0t: total_stress expected %0d actual %0d", $time,
                             exp_r.stress, total_stress);
                    errors++;
                end
            end
        end
    end

    task automatic push(mode_t op, int row, int col, logic [31:0] data);
        load_item_t it;
        it.op = op;
        it.row = row[5:0];
        it.col = col[5:0];
        it.data = data;
        if (op == MODE_WR_DIST)
            target_set[row*NPTS+col] = 1'b1;
        pending_items = {pending_items, it};
    endtask

    // Queue a run, first loading any missing targets for the points in use when the generation count is nonzero
    task automatic push_run();
        int n, i, j;
        n = pts_used > NPTS ? NPTS : pts_used;
        if (gen_total != 0)
        begin
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++)
                    if (i != j && !target_set[i*NPTS+j])
                        push(MODE_WR_DIST, i, j, $urandom_range(6 << 16));
        end
        push(MODE_RUN, 0, 0, $urandom);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        case (idx)
            CFG_MOVE_FACTOR: step_gain = val & 16'hffff;
            CFG_GEN_COUNT:   gen_total = val & 16'hffff;
            CFG_POINT_COUNT: pts_used = val & 7'h7f;
            default:         dims_used = val & 3'h7;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int unsigned mf, int unsigned gc, int unsigned pc,
                             int unsigned dc);
        wait_idle();
        set_reg(CFG_MOVE_FACTOR, mf);
        set_reg(CFG_GEN_COUNT, gc);
        set_reg(CFG_POINT_COUNT, pc);
        set_reg(CFG_DIM_COUNT, dc);
    endtask

    // Random items, mostly well-formed loads and reads with an occasional run
    task automatic random_items(int count);
        int k, sel;
        logic [31:0] v;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(99);
            if ($urandom_range(99) < 70)
                v = $signed($urandom_range(8 << 16)) - (4 << 16);
            else
                v = $urandom;
            if (sel < 30)
                push(MODE_WR_DIST, $urandom_range(63), $urandom_range(63),
                     $urandom_range(3) == 0 ? v : $urandom_range(6 << 16));
            else if (sel < 60)
                push(MODE_WR_COORD, $urandom_range(pts_used > 8 ? 7 : 5),
                     $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(3), v);
            else if (sel < 97)
                push(MODE_RD_COORD, $urandom_range(63),
                     $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(3), v);
            else
                push_run();
        end
        push_run();
    endtask

    initial
    begin
        int p;
        foreach (coord_mem[i])
            coord_mem[i] = 0;
        foreach (target_mem[i])
        begin
            target_mem[i] = 0;
            target_set[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, ignored indexes, negative target, exact match
        configure(328, 2, 2, 2);
        push(MODE_WR_COORD, 0, 0, 32'h7fffffff);
        push(MODE_WR_COORD, 0, 1, 32'h80000000);
        push(MODE_WR_COORD, 63, 3, 32'hffffffff);
        push(MODE_WR_COORD, 1, 4, 32'h12345678);
        push(MODE_WR_COORD, 1, 63, 32'h55aa55aa);
        push(MODE_RD_COORD, 0, 0, '0);
        push(MODE_RD_COORD, 0, 1, '0);
        push(MODE_RD_COORD, 63, 3, '0);
        push(MODE_RD_COORD, 1, 4, '0);
        push(MODE_RD_COORD, 1, 63, '0);
        push(MODE_WR_DIST, 0, 1, 32'h80000000);
        push(MODE_WR_DIST, 1, 0, 32'h7fffffff);
        push(MODE_WR_DIST, 63, 63, 32'hffffffff);
        push_run();
        push(MODE_RD_COORD, 0, 0, '0);
        push(MODE_RD_COORD, 0, 1, '0);
        push(MODE_RD_COORD, 1, 0, '0);
        push(MODE_RD_COORD, 1, 1, '0);
        push(MODE_WR_COORD, 0, 0, 0);
        push(MODE_WR_COORD, 0, 1, 0);
        push(MODE_WR_COORD, 1, 0, 3 << 16);
        push(MODE_WR_COORD, 1, 1, 4 << 16);
        push(MODE_WR_DIST, 0, 1, 5 << 16);
        push(MODE_WR_DIST, 1, 0, 5 << 16);
        push_run();

        // Register extremes: zero generations, clamped counts, empty runs
        configure(0, 0, 127, 7);
        push_run();
        configure(65535, 0, 64, 4);
        push_run();
        configure(65535, 65535, 0, 0);
        push_run();
        configure(200, 3, 1, 1);
        push_run();
        configure(65535, 1, 2, 0);
        push_run();

        for (p = 0; p < 6; p++)
        begin
            configure(p == 0 ? 65535 : $urandom_range(2000), $urandom_range(1, 3),
                      $urandom_range(2, 4), p < 4 ? p + 1 : $urandom_range(1, 4));
            random_items(225);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Covered %0d runs, %0d coordinate reads and %0d loads.", n_runs, n_reads,
                 n_writes);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #300ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
